// File: rtl/ccrc_pkg.sv
// ccrc_pkg: shared types, register map and bit helpers for the crc-16 engine
// no dependencies; imported by every module of the block
`default_nettype none

package ccrc_pkg;

    localparam int CRC_W  = 16;
    localparam int BYTE_W = 8;
    localparam int APB_DW = 32;
    localparam int APB_AW = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [CRC_W-1:0] CRC_TOP_BIT      = 16'h8000;
    localparam logic [CRC_W-1:0] POLY_RESET       = 16'h1021;
    localparam logic [CRC_W-1:0] INIT_RESET       = 16'hFFFF;

    // register indexes, byte address is 4 * index
    localparam logic [REG_IDX_W-1:0] REG_POLYNOMIAL    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_VALUE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REFLECT_IN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REFLECT_OUT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_XOR_OUT       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RESIDUE       = 3'd5;

    typedef struct packed {
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] initial_value;
        logic             reflect_in;
        logic             reflect_out;
        logic [CRC_W-1:0] xor_out;
        logic [CRC_W-1:0] residue;
    } ccrc_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } ccrc_in_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             residue_match;
    } ccrc_out_t;

    function automatic logic [BYTE_W-1:0] rev_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev_word(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ccrc_regs.sv
// ccrc_regs: apb-style configuration registers of the crc-16 engine
// depends on ccrc_pkg for the register map and the config struct
`default_nettype none

module ccrc_regs
    import ccrc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output ccrc_cfg_t              cfg
);

    ccrc_cfg_t             cfg_reg;
    ccrc_cfg_t             cfg_next;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_POLYNOMIAL:    cfg_next.polynomial    = pwdata[CRC_W-1:0];
                REG_INITIAL_VALUE: cfg_next.initial_value = pwdata[CRC_W-1:0];
                REG_REFLECT_IN:    cfg_next.reflect_in    = pwdata[0];
                REG_REFLECT_OUT:   cfg_next.reflect_out   = pwdata[0];
                REG_XOR_OUT:       cfg_next.xor_out       = pwdata[CRC_W-1:0];
                REG_RESIDUE:       cfg_next.residue       = pwdata[CRC_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polynomial    <= POLY_RESET;
            cfg_reg.initial_value <= INIT_RESET;
            cfg_reg.reflect_in    <= 1'b0;
            cfg_reg.reflect_out   <= 1'b0;
            cfg_reg.xor_out       <= '0;
            cfg_reg.residue       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_POLYNOMIAL:    prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_reg.polynomial};
            REG_INITIAL_VALUE: prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_reg.initial_value};
            REG_REFLECT_IN:    prdata = {{(APB_DW-1){1'b0}}, cfg_reg.reflect_in};
            REG_REFLECT_OUT:   prdata = {{(APB_DW-1){1'b0}}, cfg_reg.reflect_out};
            REG_XOR_OUT:       prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_reg.xor_out};
            REG_RESIDUE:       prdata = {{(APB_DW-CRC_W){1'b0}}, cfg_reg.residue};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ccrc_step.sv
// ccrc_step: one-byte crc-16 update with the end-of-message finish
// depends on ccrc_pkg for the config, payload types and bit reversal helpers
`default_nettype none

module ccrc_step
    import ccrc_pkg::*;
(
    input  wire ccrc_cfg_t         cfg,
    input  wire ccrc_in_t          item,
    input  wire logic [CRC_W-1:0]  crc_in,
    output logic      [CRC_W-1:0]  crc_next,
    output ccrc_out_t              result
);

    logic [BYTE_W-1:0] data_b;
    logic [CRC_W-1:0]  crc_seed;
    logic [CRC_W-1:0]  crc_shift;
    logic [CRC_W-1:0]  crc_xored;
    logic [CRC_W-1:0]  crc_final;

    always_comb begin
        data_b    = cfg.reflect_in ? rev_byte(item.data_byte) : item.data_byte;
        crc_seed  = item.first_byte ? cfg.initial_value : crc_in;
        crc_shift = crc_seed ^ {data_b, {(CRC_W-BYTE_W){1'b0}}};
        // msb-first shift through the polynomial, one bit per step
        for (int i = 0; i < BYTE_W; i++) begin
            if ((crc_shift & CRC_TOP_BIT) != '0) begin
                crc_shift = (crc_shift << 1) ^ cfg.polynomial;
            end else begin
                crc_shift = crc_shift << 1;
            end
        end
        crc_xored = crc_shift ^ cfg.xor_out;
        crc_final = cfg.reflect_out ? rev_word(crc_xored) : crc_xored;
        crc_next  = item.last_byte ? crc_final : crc_shift;
        result.crc_value     = crc_final;
        result.residue_match = ((crc_final ^ cfg.xor_out) == cfg.residue);
    end

endmodule

`default_nettype wire

// File: rtl/configurable_crc16_engine_unit.sv
// configurable_crc16_engine_unit: top level of the configurable crc-16 engine
// depends on ccrc_pkg, ccrc_regs and ccrc_step
//
// The engine takes one message byte per transaction and sustains one byte per
// clock cycle unless a last byte waits on a full result register. A byte is
// captured in an input register, then the eight-step xor-shift update runs from
// it against the running crc register, written back in the same cycle, so this
// loop through the running crc sets the one-byte-per-cycle rate. Bytes not
// marked last give no result. A byte marked last moves from the input register
// into the result register, where its result waits on m_valid while the engine
// keeps taking bytes not marked last. Configuration is to be written over the apb
// port only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module configurable_crc16_engine_unit
    import ccrc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ccrc_in_t          s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ccrc_out_t              m_payload
);

    ccrc_cfg_t        cfg;
    logic             in_valid_reg;
    logic             in_valid_next;
    ccrc_in_t         in_data_reg;
    logic [CRC_W-1:0] running_crc_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    ccrc_out_t        out_data_reg;
    logic [CRC_W-1:0] crc_step_next;
    ccrc_out_t        step_result;
    logic             advance;
    logic             s_take;

    ccrc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccrc_step u_step (
        .cfg      (cfg),
        .item     (in_data_reg),
        .crc_in   (running_crc_reg),
        .crc_next (crc_step_next),
        .result   (step_result)
    );

    // a last byte moves on only when the result register is free or draining
    assign advance = in_valid_reg &&
                     (!in_data_reg.last_byte || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && in_data_reg.last_byte) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            running_crc_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                running_crc_reg <= crc_step_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_payload;
        end
        if (advance && in_data_reg.last_byte) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    a_crc_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(running_crc_reg))
        else $error("running crc changed without a byte");

    a_last_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.last_byte) |=>
            (m_valid && m_payload.crc_value == running_crc_reg))
        else $error("result does not match the finished crc");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_data_reg.last_byte && out_valid_reg && !m_ready)
            |-> !advance)
        else $error("pending result would be overwritten");

endmodule

`default_nettype wire

// File: bench/configurable_crc16_engine_unit_test.sv
// testbench for configurable_crc16_engine_unit: directed byte table, then random
// messages under several crc settings, checked against an in-bench crc predictor
// depends on ccrc_pkg and the rtl of configurable_crc16_engine_unit
`default_nettype none

module configurable_crc16_engine_unit_test
    import ccrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int QUIET_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_BYTES  = 160;
    localparam int NUM_ROWS     = 25;

    // indexes past the register list, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        ccrc_in_t  item;
        logic      pin;
        ccrc_out_t want;
    } row_t;

    typedef struct packed {
        logic      pin;
        ccrc_out_t want;
    } pin_t;

    // "123456789" under the reset setting gives 29b1, with 29 b1 appended it gives 0
    localparam row_t DIRECTED [NUM_ROWS] = '{
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{16'h0000, 1'b1}},
        '{'{8'h31, 1'b1, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h32, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h33, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h34, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h35, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h36, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h37, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h38, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h39, 1'b0, 1'b1}, 1'b1, '{16'h29B1, 1'b0}},
        '{'{8'h00, 1'b0, 1'b1}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h31, 1'b1, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h32, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h33, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h34, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h35, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h36, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h37, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h38, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h39, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h29, 1'b0, 1'b0}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'hB1, 1'b0, 1'b1}, 1'b1, '{16'h0000, 1'b1}},
        '{'{8'hFF, 1'b1, 1'b1}, 1'b1, '{16'hFF00, 1'b0}},
        '{'{8'h00, 1'b1, 1'b1}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'h80, 1'b1, 1'b0}, 1'b0, '{16'h0000, 1'b0}}
    };

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    ccrc_in_t          s_payload = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    ccrc_out_t         m_payload;

    configurable_crc16_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // predictor state: its own copy of the settings and the running crc
    ccrc_cfg_t   crc_cfg;
    logic [15:0] crc_running;
    ccrc_out_t   crc_expect_q[$];
    pin_t        pinned_q[$];
    int          crc_errors;
    int unsigned cycle_count;
    int          bytes_sent;
    bit          src_calm;
    bit          sink_calm;
    bit          long_hold_req;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[i] = v[7-i];
        return r;
    endfunction

    function automatic logic [15:0] mirror16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) r[i] = v[15-i];
        return r;
    endfunction

    // xor the byte into the high half, then eight msb-first division steps
    function automatic logic [15:0] shift_byte(input logic [15:0] acc, input logic [7:0] d,
                                               input logic [15:0] poly);
        logic [15:0] r;
        r = acc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ poly) : (r << 1);
        return r;
    endfunction

    function automatic bit crc_advance(input ccrc_in_t b, output ccrc_out_t res);
        logic [15:0] acc;
        logic [7:0]  d;
        acc = b.first_byte ? crc_cfg.initial_value : crc_running;
        d   = crc_cfg.reflect_in ? mirror8(b.data_byte) : b.data_byte;
        acc = shift_byte(acc, d, crc_cfg.polynomial);
        res = '0;
        if (!b.last_byte) begin
            crc_running = acc;
            return 1'b0;
        end
        acc = acc ^ crc_cfg.xor_out;
        if (crc_cfg.reflect_out) acc = mirror16(acc);
        crc_running       = acc;
        res.crc_value     = acc;
        res.residue_match = ((acc ^ crc_cfg.xor_out) == crc_cfg.residue);
        return 1'b1;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // accepted input transactions feed the predictor
    always @(posedge aclk) begin
        ccrc_out_t res;
        pin_t      pin;
        if (aresetn && s_valid && s_ready) begin
            pin = pinned_q.pop_front();
            if (crc_advance(s_payload, res)) begin
                crc_expect_q.push_back(pin.pin ? pin.want : res);
            end
        end
    end

    always @(posedge aclk) begin
        ccrc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (crc_expect_q.size() == 0) begin
                crc_errors++;
                if (crc_errors <= 10)
                    $display("unexpected crc result crc %h match %b",
                             m_payload.crc_value, m_payload.residue_match);
            end else begin
                want = crc_expect_q.pop_front();
                if (m_payload.crc_value !== want.crc_value ||
                    m_payload.residue_match !== want.residue_match) begin
                    crc_errors++;
                    if (crc_errors <= 10)
                        $display("crc result wrong: expected crc %h match %b, got crc %h match %b",
                                 want.crc_value, want.residue_match,
                                 m_payload.crc_value, m_payload.residue_match);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("configurable_crc16_engine_unit: mismatch");
            $finish;
        end
    end

    // result side back-pressure, with a long hold-off on request
    initial begin
        int gap;
        gap = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
                gap = pick_gap(sink_calm);
            end
        end
    end

    task automatic send_byte(input ccrc_in_t b, input pin_t pin);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pinned_q.push_back(pin);
        s_valid   <= 1'b1;
        s_payload <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (crc_expect_q.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // apb write with a setup phase then an access phase, upper data bits carry junk that must be masked off
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        logic [31:0] junk;
        logic [31:0] word;
        junk = $urandom;
        if (idx == REG_REFLECT_IN || idx == REG_REFLECT_OUT)
            word = {junk[31:1], data[0]};
        else
            word = {junk[31:16], data[15:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_POLYNOMIAL:    crc_cfg.polynomial    = word[15:0];
            REG_INITIAL_VALUE: crc_cfg.initial_value = word[15:0];
            REG_REFLECT_IN:    crc_cfg.reflect_in    = word[0];
            REG_REFLECT_OUT:   crc_cfg.reflect_out   = word[0];
            REG_XOR_OUT:       crc_cfg.xor_out       = word[15:0];
            REG_RESIDUE:       crc_cfg.residue       = word[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly well-formed messages, some carrying their own crc so the check can hit
    task automatic send_message();
        logic [7:0]  msg[$];
        logic [15:0] acc;
        int          len;
        int          kind;
        ccrc_in_t    b;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 19) == 0) src_calm = !src_calm;
        if (kind < 2) begin
            b = ccrc_in_t'($urandom);
            send_byte(b, '0);
            return;
        end
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) msg.push_back(8'($urandom_range(0, 255)));
        if (kind >= 7) begin
            acc = crc_cfg.initial_value;
            foreach (msg[i])
                acc = shift_byte(acc, crc_cfg.reflect_in ? mirror8(msg[i]) : msg[i],
                                 crc_cfg.polynomial);
            msg.push_back(crc_cfg.reflect_in ? mirror8(acc[15:8]) : acc[15:8]);
            msg.push_back(crc_cfg.reflect_in ? mirror8(acc[7:0]) : acc[7:0]);
        end
        foreach (msg[i]) begin
            b.data_byte  = msg[i];
            b.first_byte = (i == 0);
            b.last_byte  = (i == msg.size() - 1);
            send_byte(b, '0);
        end
    endtask

    initial begin
        ccrc_cfg_t next_cfg;
        pin_t      pin;
        ccrc_in_t  b;
        crc_cfg = '{POLY_RESET, INIT_RESET, 1'b0, 1'b0, 16'h0000, 16'h0000};
        crc_running = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            pin.pin  = DIRECTED[r].pin;
            pin.want = DIRECTED[r].want;
            send_byte(DIRECTED[r].item, pin);
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: next_cfg = '{16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000};
                1: next_cfg = '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'h0000};
                2: next_cfg = '{16'h8005, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000};
                3: next_cfg = '{16'h1021, 16'h0000, 1'b1, 1'b0, 16'hFFFF, 16'h0000};
                4: next_cfg = '{16'h3D65, 16'h0000, 1'b0, 1'b1, 16'hFFFF, 16'h0000};
                default: next_cfg = ccrc_cfg_t'({$urandom, $urandom, $urandom});
            endcase
            // residue that a message with its own crc appended lands on
            next_cfg.residue = (next_cfg.reflect_out ? mirror16(next_cfg.xor_out)
                                                     : next_cfg.xor_out) ^ next_cfg.xor_out;
            if (p == 1) next_cfg.residue = 16'hFFFF;
            else if (p >= 5 && $urandom_range(0, 3) == 0) next_cfg.residue = 16'($urandom);
            write_reg(REG_POLYNOMIAL, 32'(next_cfg.polynomial));
            write_reg(REG_INITIAL_VALUE, 32'(next_cfg.initial_value));
            write_reg(REG_REFLECT_IN, 32'(next_cfg.reflect_in));
            write_reg(REG_REFLECT_OUT, 32'(next_cfg.reflect_out));
            write_reg(REG_XOR_OUT, 32'(next_cfg.xor_out));
            write_reg(REG_RESIDUE, 32'(next_cfg.residue));
            if (p == 0) begin
                write_reg(REG_UNMAPPED_LO, $urandom);
                write_reg(REG_UNMAPPED_HI, $urandom);
            end
            @(posedge aclk);

            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) send_message();

            if (p == 0) begin
                // stall the result side while one-byte messages keep coming
                drain_results();
                long_hold_req = 1'b1;
                src_calm = 1'b1;
                for (int i = 0; i < 30; i++) begin
                    b.data_byte  = 8'($urandom_range(0, 255));
                    b.first_byte = 1'b1;
                    b.last_byte  = 1'b1;
                    send_byte(b, '0);
                end
                src_calm = 1'b0;
            end
            drain_results();
        end

        if (crc_errors == 0 && crc_expect_q.size() == 0) begin
            $display("configurable_crc16_engine_unit: match");
        end else begin
            $display("configurable_crc16_engine_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
